/* rtl/assert_macros.svh */
// Shared assertion macros for the graph store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AMGS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define AMGS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/amgs_pkg.sv */
`default_nettype none

package amgs_pkg;

  // Build-time sizes
  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;

  localparam int VIDX_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
  localparam int BIDX_W   = VIDX_W + 1;
  localparam int ROW_BITS = MAX_VERTICES * WEIGHT_BITS;

  // Port field widths
  localparam int OPC_W   = 3;
  localparam int VERT_W  = 8;
  localparam int EW_W    = 16;
  localparam int NMASK_W = 16;
  localparam int MDV_W   = 5;
  localparam int VC_W    = 5;

  localparam logic [VC_W-1:0] VC_RESET = VC_W'(16);

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_EXISTS     = 3'd2,
    OP_NEIGHBORS  = 3'd3,
    OP_MAX_DEGREE = 3'd4
  } opcode_e;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef weight_t [MAX_VERTICES-1:0] row_t;

  // All ones marks a missing edge
  localparam weight_t NO_EDGE = '1;

  // One matrix row as seen by the control logic
  typedef struct packed {
    row_t                    row;
    logic [MAX_VERTICES-1:0] mask;
    logic [CNT_W-1:0]        degree;
  } row_info_t;

endpackage

`default_nettype wire

/* rtl/amgs_if.sv */
`default_nettype none

// Request channel: one graph operation per item.
interface amgs_in_if import amgs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic [VERT_W-1:0]        vertex_a;
  logic [VERT_W-1:0]        vertex_b;
  logic signed [EW_W-1:0]   edge_weight;

  modport source (output valid, output opcode, output vertex_a, output vertex_b,
                  output edge_weight, input ready);
  modport sink   (input valid, input opcode, input vertex_a, input vertex_b,
                  input edge_weight, output ready);
endinterface

// Result channel: one answer per request item.
interface amgs_out_if import amgs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               status;
  logic               edge_exists;
  logic [NMASK_W-1:0] neighbor_mask;
  logic [MDV_W-1:0]   max_degree_vertex;

  modport source (output valid, output status, output edge_exists,
                  output neighbor_mask, output max_degree_vertex, input ready);
  modport sink   (input valid, input status, input edge_exists,
                  input neighbor_mask, input max_degree_vertex, output ready);
endinterface

`default_nettype wire

/* rtl/adjacency_matrix_graph_store_core.sv */
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+---------------------------------------------
// in_i      | in  | valid / ready      | opcode, vertex_a, vertex_b, edge_weight
// out_o     | out | valid / ready      | status, edge_exists, neighbor_mask,
//           |     |                    |   max_degree_vertex
// cfg       | in  | cfg_we_i           | cfg_wdata_i = vertex_count
//
// One item at a time through the matrix RAM (one row per word, one read and one
// write port). Invalid and unknown items go straight to the result; exists and
// neighbors read one row; add and remove rewrite row a, then row b if it differs;
// max degree reads vertex_count rows back to back, capped at MAX_VERTICES.
// Reset clears row valid bits at once, so no clearing pass is needed.
// A finished result waits in the output register while the next item is
// accepted; a stalled output holds the item in flight at its last step.
`default_nettype none

module adjacency_matrix_graph_store_core import amgs_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [VC_W-1:0] cfg_wdata_i,
  amgs_in_if.sink              in_i,
  amgs_out_if.source           out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_A,
    S_WR_B,
    S_QUERY,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [VC_W-1:0]         vc_q;
  logic [OPC_W-1:0]        op_q, op_d;
  logic [VIDX_W-1:0]       ia_q, ia_d, ib_q, ib_d;
  weight_t                 w_q, w_d;
  logic [MAX_VERTICES-1:0] rv_q, rv_d;
  logic                    rd_rv_q;
  logic [VIDX_W-1:0]       row_q, row_d;
  logic [VIDX_W-1:0]       best_q, best_d;
  logic [CNT_W-1:0]        bestc_q, bestc_d;
  logic                    res_st_q, res_st_d;
  logic                    res_ex_q, res_ex_d;
  logic [NMASK_W-1:0]      res_mask_q, res_mask_d;
  logic [MDV_W-1:0]        res_mdv_q, res_mdv_d;
  logic                    out_vld_q, out_vld_d;
  logic                    out_st_q, out_ex_q;
  logic [NMASK_W-1:0]      out_mask_q;
  logic [MDV_W-1:0]        out_mdv_q;

  logic [CNT_W-1:0]        vcount;
  logic                    va, vb;
  logic [VIDX_W-1:0]       in_ia, in_ib;
  logic                    ram_we, ram_re;
  logic [VIDX_W-1:0]       ram_waddr, ram_raddr;
  row_t                    ram_wdata, ram_rdata;
  row_info_t               info;
  logic                    out_free;
  logic [VIDX_W-1:0]       best_new;

  // Saturate the vertex count to the built size
  assign vcount = (int'(vc_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_q);

  // Check and index the request vertices
  assign va    = (in_i.vertex_a != '0) && (in_i.vertex_a <= VERT_W'(vcount));
  assign vb    = (in_i.vertex_b != '0) && (in_i.vertex_b <= VERT_W'(vcount));
  assign in_ia = VIDX_W'(in_i.vertex_a - VERT_W'(1));
  assign in_ib = VIDX_W'(in_i.vertex_b - VERT_W'(1));

  assign in_i.ready = (state_q == S_IDLE);
  assign out_free   = !out_vld_q || out_o.ready;

  amgs_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  amgs_row_eval u_row_eval (
    .rdata_i     (ram_rdata),
    .row_valid_i (rd_rv_q),
    .vcount_i    (vcount),
    .info_o      (info)
  );

  assign best_new = (info.degree > bestc_q) ? row_q : best_q;

  // Sequence each item through reads, write-backs and the row scan
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ia_d       = ia_q;
    ib_d       = ib_q;
    w_d        = w_q;
    rv_d       = rv_q;
    row_d      = row_q;
    best_d     = best_q;
    bestc_d    = bestc_q;
    res_st_d   = res_st_q;
    res_ex_d   = res_ex_q;
    res_mask_d = res_mask_q;
    res_mdv_d  = res_mdv_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    ram_we     = 1'b0;
    ram_waddr  = ia_q;
    ram_wdata  = info.row;
    ram_re     = 1'b0;
    ram_raddr  = in_ia;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d       = in_i.opcode;
          ia_d       = in_ia;
          ib_d       = in_ib;
          w_d        = (in_i.opcode == OP_ADD) ? WEIGHT_BITS'(in_i.edge_weight) : NO_EDGE;
          res_st_d   = STATUS_OK;
          res_ex_d   = 1'b0;
          res_mask_d = '0;
          res_mdv_d  = '0;
          state_d    = S_DONE;
          case (in_i.opcode)
            OP_ADD, OP_REMOVE: begin
              if (va && vb) begin
                ram_re  = 1'b1;
                state_d = S_WR_A;
              end else begin
                res_st_d = STATUS_INVALID;
              end
            end
            OP_EXISTS: begin
              if (va && vb) begin
                ram_re  = 1'b1;
                state_d = S_QUERY;
              end else begin
                res_st_d = STATUS_INVALID;
              end
            end
            OP_NEIGHBORS: begin
              if (va) begin
                ram_re  = 1'b1;
                state_d = S_QUERY;
              end else begin
                res_st_d = STATUS_INVALID;
              end
            end
            OP_MAX_DEGREE: begin
              if (vcount == '0) begin
                res_mdv_d = MDV_W'(1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                row_d     = '0;
                best_d    = '0;
                bestc_d   = '0;
                state_d   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Write entry (a, b); fetch row b unless it is the same row
      S_WR_A: begin
        ram_we          = 1'b1;
        ram_waddr       = ia_q;
        ram_wdata       = info.row;
        ram_wdata[ib_q] = w_q;
        rv_d[ia_q]      = 1'b1;
        if (ia_q == ib_q) begin
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ib_q;
          state_d   = S_WR_B;
        end
      end

      // Write the mirror entry (b, a)
      S_WR_B: begin
        ram_we          = 1'b1;
        ram_waddr       = ib_q;
        ram_wdata       = info.row;
        ram_wdata[ia_q] = w_q;
        rv_d[ib_q]      = 1'b1;
        state_d         = S_DONE;
      end

      S_QUERY: begin
        if (op_q == OP_EXISTS) begin
          res_ex_d = info.mask[ib_q];
        end else begin
          res_mask_d = NMASK_W'(info.mask);
        end
        state_d = S_DONE;
      end

      // Rate one row per cycle while the next row is read
      S_SCAN: begin
        best_d  = best_new;
        bestc_d = (info.degree > bestc_q) ? info.degree : bestc_q;
        if ((BIDX_W'(row_q) + BIDX_W'(1)) == BIDX_W'(vcount)) begin
          res_mdv_d = MDV_W'(BIDX_W'(best_new) + BIDX_W'(1));
          state_d   = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = row_q + VIDX_W'(1);
          row_d     = row_q + VIDX_W'(1);
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vc_q      <= VC_RESET;
      rv_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rv_q      <= rv_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
    end
  end

  // Item payload and result registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ia_q       <= ia_d;
    ib_q       <= ib_d;
    w_q        <= w_d;
    row_q      <= row_d;
    best_q     <= best_d;
    bestc_q    <= bestc_d;
    res_st_q   <= res_st_d;
    res_ex_q   <= res_ex_d;
    res_mask_q <= res_mask_d;
    res_mdv_q  <= res_mdv_d;
    if (ram_re) begin
      rd_rv_q <= rv_q[ram_raddr];
    end
    if ((state_q == S_DONE) && out_free) begin
      out_st_q   <= res_st_q;
      out_ex_q   <= res_ex_q;
      out_mask_q <= res_mask_q;
      out_mdv_q  <= res_mdv_q;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.status            = out_st_q;
  assign out_o.edge_exists       = out_ex_q;
  assign out_o.neighbor_mask     = out_mask_q;
  assign out_o.max_degree_vertex = out_mdv_q;

endmodule

`default_nettype wire

/* rtl/amgs_ram.sv */
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module amgs_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data is valid in the cycle after the request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/amgs_row_eval.sv */
`default_nettype none

// Decode one matrix row: effective weights, edge mask and degree.
module amgs_row_eval import amgs_pkg::*; (
  input  wire row_t             rdata_i,
  input  wire logic             row_valid_i,
  input  wire logic [CNT_W-1:0] vcount_i,
  output      row_info_t        info_o
);

  row_t                    row;
  logic [MAX_VERTICES-1:0] mask;

  always_comb begin
    // Treat a never-written row as all no-edge
    row = row_valid_i ? rdata_i : {MAX_VERTICES{NO_EDGE}};
    // Keep only columns of vertices in use
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (row[i] != NO_EDGE) && (CNT_W'(i) < vcount_i);
    end
  end

  assign info_o.row    = row;
  assign info_o.mask   = mask;
  assign info_o.degree = CNT_W'($countones(mask));

endmodule

`default_nettype wire

/* rtl/amgs_checker.sv */
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the graph store.
module amgs_checker import amgs_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               out_status_i,
  input wire logic [NMASK_W-1:0] out_neighbor_mask_i,
  input wire logic [MDV_W-1:0]   out_max_degree_vertex_i
);

  logic [2:0] pending_q;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {2'b0, in_valid_i && in_ready_i}
                             - {2'b0, out_valid_i && out_ready_i};
    end
  end

  `AMGS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) && $stable(out_neighbor_mask_i) && $stable(out_max_degree_vertex_i), "stalled result changed")
  `AMGS_ASSERT(a_no_orphan, clk_i, rst_ni, out_valid_i |-> pending_q != 3'd0, "result without an accepted item")
  `AMGS_ASSERT(a_in_flight, clk_i, rst_ni, pending_q < 3'd3, "more than two items in flight")
  `AMGS_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "item accepted while busy")

endmodule

bind adjacency_matrix_graph_store_core amgs_checker u_amgs_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .in_valid_i              (in_i.valid),
  .in_ready_i              (in_i.ready),
  .out_valid_i             (out_o.valid),
  .out_ready_i             (out_o.ready),
  .out_status_i            (out_o.status),
  .out_neighbor_mask_i     (out_o.neighbor_mask),
  .out_max_degree_vertex_i (out_o.max_degree_vertex)
);

`default_nettype wire
